// ===== hdl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Types and constants shared by the square table text parser.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int MAX_ORDER = 64;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_KW       = 4'd1,
        PH_ASSIGN0  = 4'd2,
        PH_ASSIGN1  = 4'd3,
        PH_OPEN     = 4'd4,
        PH_LIST     = 4'd5,
        PH_TAB      = 4'd6,
        PH_NUMSTART = 4'd7,
        PH_AFTERNUM = 4'd8,
        PH_AFTERROW = 4'd9,
        PH_ROWOPEN  = 4'd10,
        PH_CLOSED   = 4'd11
    } stp_phase_t;

    typedef enum logic [1:0] {
        KIND_ENTRY  = 2'd0,
        KIND_TABLE  = 2'd1,
        KIND_CLOSED = 2'd2,
        KIND_ERROR  = 2'd3
    } stp_kind_t;

    typedef enum logic [2:0] {
        ERR_BAD_CHAR   = 3'd0,
        ERR_EARLY_END  = 3'd1,
        ERR_ROW_LENGTH = 3'd2,
        ERR_ROW_COUNT  = 3'd3,
        ERR_VALUE      = 3'd4,
        ERR_ORDER_BIG  = 3'd5
    } stp_err_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } stp_in_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [5:0] row_index;
        logic [5:0] column_index;
        logic [5:0] entry_value;
        logic [6:0] table_order;
        logic [2:0] error_code;
        logic       last_of_run;
    } stp_out_t;

    // results produced by the front for one byte
    typedef struct packed {
        logic     valid0;
        logic     valid1;
        stp_out_t res0;
        stp_out_t res1;
    } stp_push_t;

endpackage

// ===== hdl/square_table_text_parser_unit.sv =====
// ----------------------------------------------------------------------------
// square_table_text_parser_unit
// Parses a bracketed list of square integer tables from a byte stream.
//
//   channel   dir  payload    handshake
//   item      in   stp_in_t   item_valid / item_stall
//   result    out  stp_out_t  result_valid / result_stall
//
// One byte per cycle while item_stall is low; the parser is a character FSM.
// A byte yields at most two results, queued four deep ahead of the output.
// item_stall rises when fewer than two queue slots are free.
// Asynchronous active-low reset returns the parser to the list prefix.
// ----------------------------------------------------------------------------
module square_table_text_parser_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  stp_pkg::stp_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output stp_pkg::stp_out_t result
);
    import stp_pkg::*;

    stp_push_t  push;
    logic [2:0] level;
    logic       fire;
    logic       pop;

    assign item_stall   = (level > 3'(QUEUE_DEPTH - 2));
    assign fire         = item_valid && !item_stall;
    assign result_valid = (level != 3'd0);
    assign pop          = result_valid && !result_stall;

    stp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .push  (push)
    );

    stp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (result),
        .level (level)
    );

`ifndef SYNTH
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_two_only_with_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0 && push.res1.result_kind == KIND_ERROR)
        else $error("second result without first");

    a_closed_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && result.result_kind == KIND_CLOSED |-> result.last_of_run)
        else $error("list close not last");
`endif

endmodule

// ===== hdl/stp_front.sv =====
// ----------------------------------------------------------------------------
// stp_front
// Character parser: takes one byte per transfer, yields up to two results.
// ----------------------------------------------------------------------------
module stp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  stp_pkg::stp_in_t  item,
    output stp_pkg::stp_push_t push
);
    import stp_pkg::*;

    localparam logic [7:0] KW0 = 8'h74; // t
    localparam logic [7:0] KW1 = 8'h61; // a
    localparam logic [7:0] KW2 = 8'h62; // b
    localparam logic [7:0] KW3 = 8'h6c; // l
    localparam logic [7:0] KW4 = 8'h65; // e
    localparam logic [7:0] KW5 = 8'h73; // s
    localparam logic [7:0] CH_LB = 8'h5b;
    localparam logic [7:0] CH_RB = 8'h5d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_EQ = 8'h3d;
    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [6:0] NUM_SAT = 7'(MAX_ORDER + 1);

    stp_phase_t phase_reg, phase_next;
    logic [2:0] kw_pos_reg, kw_pos_next;
    logic       comment_reg, comment_next;
    logic [6:0] num_reg, num_next;
    logic       num_act_reg, num_act_next;
    logic [6:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;
    logic [6:0] order_reg, order_next;
    logic       known_reg, known_next;
    logic [6:0] fmax_reg, fmax_next;
    logic       err_reg, err_next;

    logic       v0, v1;
    stp_out_t   r0, r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            kw_pos_reg  <= '0;
            comment_reg <= 1'b0;
            num_reg     <= '0;
            num_act_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            order_reg   <= '0;
            known_reg   <= 1'b0;
            fmax_reg    <= '0;
            err_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            kw_pos_reg  <= kw_pos_next;
            comment_reg <= comment_next;
            num_reg     <= num_next;
            num_act_reg <= num_act_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            order_reg   <= order_next;
            known_reg   <= known_next;
            fmax_reg    <= fmax_next;
            err_reg     <= err_next;
        end
    end

    // next state and raw results
    always_comb
    begin
        logic [7:0] b;
        logic       digit;
        logic [9:0] acc;
        logic       go;
        logic       cnt;
        logic       kw_hit;
        stp_out_t   blank;
        b = item.text_byte;
        digit = (b >= 8'h30) && (b <= 8'h39);
        acc = '0;
        go = 1'b1;
        cnt = 1'b0;
        kw_hit = 1'b0;
        blank = '0;
        phase_next   = phase_reg;
        kw_pos_next  = kw_pos_reg;
        comment_next = comment_reg;
        num_next     = num_reg;
        num_act_next = num_act_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        order_next   = order_reg;
        known_next   = known_reg;
        fmax_next    = fmax_reg;
        err_next     = err_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        r0 = blank;
        r1 = blank;

        if (err_reg || phase_reg == PH_CLOSED)
        begin
            go = 1'b0;
        end
        else if (item.end_of_input)
        begin
            go = 1'b0;
            err_next = 1'b1;
            v0 = 1'b1;
            r0.result_kind = KIND_ERROR;
            r0.error_code = ERR_EARLY_END;
        end
        else if (comment_reg)
        begin
            go = 1'b0;
            if (b == CH_NL)
                comment_next = 1'b0;
        end
        else if (num_act_reg)
        begin
            if (digit)
            begin
                go = 1'b0;
                acc = 10'(num_reg) * 10'd10 + 10'(b[3:0]);
                num_next = (acc > 10'(NUM_SAT)) ? NUM_SAT : acc[6:0];
            end
            else
            begin
                // number ends here: entry or error
                num_act_next = 1'b0;
                num_next = '0;
                cnt = 1'b1;
                v0 = 1'b1;
                if (!known_reg && col_reg >= 7'(MAX_ORDER))
                begin
                    err_next = 1'b1;
                    r0.result_kind = KIND_ERROR;
                    r0.error_code = ERR_ORDER_BIG;
                end
                else if (!known_reg && num_reg == '0)
                begin
                    err_next = 1'b1;
                    r0.result_kind = KIND_ERROR;
                    r0.error_code = ERR_VALUE;
                end
                else if (known_reg && col_reg >= order_reg)
                begin
                    err_next = 1'b1;
                    r0.result_kind = KIND_ERROR;
                    r0.error_code = ERR_ROW_LENGTH;
                end
                else if (known_reg && (num_reg == '0 || num_reg > order_reg))
                begin
                    err_next = 1'b1;
                    r0.result_kind = KIND_ERROR;
                    r0.error_code = ERR_VALUE;
                end
                else
                begin
                    if (!known_reg && num_reg > fmax_reg)
                        fmax_next = num_reg;
                    r0.result_kind = KIND_ENTRY;
                    r0.row_index = row_reg[5:0];
                    r0.column_index = col_reg[5:0];
                    r0.entry_value = 6'(num_reg - 7'd1);
                    col_next = col_reg + 7'd1;
                end
                if (err_next)
                    go = 1'b0;
            end
        end

        if (go && phase_reg != PH_KW && phase_reg != PH_ASSIGN1)
        begin
            if (b == 8'h20 || (b >= 8'd9 && b <= 8'd13))
                go = 1'b0;
            else if (b == CH_HASH)
            begin
                go = 1'b0;
                comment_next = 1'b1;
            end
        end

        if (go)
        begin
            case (kw_pos_reg)
                3'd0: kw_hit = (b == KW0);
                3'd1: kw_hit = (b == KW1);
                3'd2: kw_hit = (b == KW2);
                3'd3: kw_hit = (b == KW3);
                3'd4: kw_hit = (b == KW4);
                3'd5: kw_hit = (b == KW5);
                default: kw_hit = 1'b0;
            endcase
            // second result slot: error marked with kind and code below
            case (phase_reg)
                PH_START:
                begin
                    if (b == KW0)
                    begin
                        kw_pos_next = 3'd1;
                        phase_next = PH_KW;
                    end
                    else if (b == CH_LB)
                        phase_next = PH_LIST;
                    else
                        err_next = 1'b1;
                end
                PH_KW:
                begin
                    if (kw_hit)
                    begin
                        kw_pos_next = kw_pos_reg + 3'd1;
                        if (kw_pos_reg == 3'd5)
                            phase_next = PH_ASSIGN0;
                    end
                    else
                        err_next = 1'b1;
                end
                PH_ASSIGN0:
                begin
                    if (b == CH_COLON) phase_next = PH_ASSIGN1;
                    else err_next = 1'b1;
                end
                PH_ASSIGN1:
                begin
                    if (b == CH_EQ) phase_next = PH_OPEN;
                    else err_next = 1'b1;
                end
                PH_OPEN:
                begin
                    if (b == CH_LB) phase_next = PH_LIST;
                    else err_next = 1'b1;
                end
                PH_LIST:
                begin
                    if (b == CH_LB)
                    begin
                        row_next = '0;
                        col_next = '0;
                        order_next = '0;
                        known_next = 1'b0;
                        fmax_next = '0;
                        phase_next = PH_TAB;
                    end
                    else if (b == CH_RB)
                    begin
                        phase_next = PH_CLOSED;
                        v0 = 1'b1;
                        r0.result_kind = KIND_CLOSED;
                    end
                    else if (b != CH_COMMA)
                        err_next = 1'b1;
                end
                PH_TAB, PH_ROWOPEN:
                begin
                    if (b == CH_LB)
                    begin
                        if (known_reg && row_reg >= order_reg)
                        begin
                            err_next = 1'b1;
                            v0 = 1'b1;
                            r0.result_kind = KIND_ERROR;
                            r0.error_code = ERR_ROW_COUNT;
                        end
                        else
                        begin
                            col_next = '0;
                            phase_next = PH_NUMSTART;
                        end
                    end
                    else
                        err_next = 1'b1;
                end
                PH_NUMSTART:
                begin
                    if (digit)
                    begin
                        num_next = {3'b000, b[3:0]};
                        num_act_next = 1'b1;
                        phase_next = PH_AFTERNUM;
                    end
                    else
                        err_next = 1'b1;
                end
                PH_AFTERNUM:
                begin
                    if (b == CH_RB)
                    begin
                        if (!known_reg)
                        begin
                            order_next = col_next;
                            known_next = 1'b1;
                        end
                        if (!known_reg && fmax_next > col_next)
                        begin
                            err_next = 1'b1;
                            r1.error_code = ERR_VALUE;
                        end
                        else if (known_reg && col_next != order_reg)
                        begin
                            err_next = 1'b1;
                            r1.error_code = ERR_ROW_LENGTH;
                        end
                        else
                        begin
                            row_next = row_reg + 7'd1;
                            phase_next = PH_AFTERROW;
                        end
                    end
                    else if (b == CH_COMMA)
                        phase_next = PH_NUMSTART;
                    else
                        err_next = 1'b1;
                end
                PH_AFTERROW:
                begin
                    if (b == CH_RB)
                    begin
                        if (row_reg != order_reg)
                        begin
                            err_next = 1'b1;
                            r1.error_code = ERR_ROW_COUNT;
                        end
                        else
                        begin
                            v0 = 1'b1;
                            r0.result_kind = KIND_TABLE;
                            r0.table_order = order_reg;
                            phase_next = PH_LIST;
                        end
                    end
                    else if (b == CH_COMMA)
                        phase_next = PH_ROWOPEN;
                    else
                        err_next = 1'b1;
                end
                default: err_next = 1'b1;
            endcase

            // an error raised by the byte itself (row count on open already sent)
            if (err_next && !(phase_reg == PH_TAB || phase_reg == PH_ROWOPEN)
                || (err_next && b != CH_LB))
            begin
                r1.result_kind = KIND_ERROR;
                if (cnt)
                begin
                    v1 = 1'b1;
                end
                else
                begin
                    v0 = 1'b1;
                    r0.result_kind = KIND_ERROR;
                    r0.error_code = r1.error_code;
                end
            end
        end
    end

    // output slots with end-of-run marks
    always_comb
    begin
        push.valid0 = fire && v0;
        push.valid1 = fire && v0 && v1;
        push.res0 = r0;
        push.res1 = r1;
        push.res0.last_of_run = !v1;
        push.res1.last_of_run = 1'b1;
    end

endmodule

// ===== hdl/stp_queue.sv =====
// ----------------------------------------------------------------------------
// stp_queue
// Result queue: up to two writes and one read per cycle, head read from the storage array.
// ----------------------------------------------------------------------------
module stp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  stp_pkg::stp_push_t push,
    input  logic               pop,
    output stp_pkg::stp_out_t  head,
    output logic [2:0]         level
);
    import stp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    stp_out_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_reg, wr_next;
    logic [PW-1:0]     rd_reg, rd_next;
    logic [2:0]        cnt_reg, cnt_next;

    always_comb
    begin
        logic [1:0] n_in;
        n_in = {1'b0, push.valid0} + {1'b0, push.valid1};
        wr_next = wr_reg + PW'(n_in);
        rd_next = rd_reg + PW'(pop);
        cnt_next = cnt_reg + 3'(n_in) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
            mem_reg[wr_reg] <= push.res0;
        if (push.valid1)
            mem_reg[wr_reg + PW'(1)] <= push.res1;
    end

    assign head  = mem_reg[rd_reg];
    assign level = cnt_reg;

endmodule
